// ===== sv/rbi_pkg.sv =====
package rbi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = 32;
    localparam int HALF_W    = 31;
    localparam int NUM_W     = COORD_W + 2;
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH = 2'd2;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(32768);

    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] NORMAL_POS_X = 3'd0;
    localparam logic [2:0] NORMAL_NEG_X = 3'd1;
    localparam logic [2:0] NORMAL_POS_Y = 3'd2;
    localparam logic [2:0] NORMAL_NEG_Y = 3'd3;
    localparam logic [2:0] NORMAL_POS_Z = 3'd4;
    localparam logic [2:0] NORMAL_NEG_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                      hit;
        logic [HALF_W-1:0]         t_hit;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [2:0]                normal_code;
    } hit_t;

endpackage

// ===== sv/rbi_div.sv =====
module rbi_div (
    input  logic                                  clk,
    input  logic signed [rbi_pkg::NUM_W-1:0]      num,
    input  logic signed [rbi_pkg::COORD_W-1:0]    den,
    output logic signed [rbi_pkg::COORD_W-1:0]    quo
);

    localparam int W  = rbi_pkg::COORD_W;
    localparam int F  = rbi_pkg::FRAC_BITS;
    localparam int NS = rbi_pkg::DIV_STEPS;
    localparam int MW = W + 1;
    localparam int SW = MW + F;

    logic [rbi_pkg::NUM_W-1:0] num_mag;
    logic [W-1:0]              den_mag;
    logic [SW-1:0]             scaled;
    logic [W-1:0]              rem_init;

    logic [W-1:0] rem_reg  [0:NS];
    logic [W-1:0] bits_reg [0:NS];
    logic [W-1:0] q_reg    [0:NS];
    logic [W-1:0] den_reg  [0:NS];
    logic         neg_reg  [0:NS];
    logic         ovf_reg  [0:NS];

    logic signed [W-1:0] quo_next;
    logic signed [W-1:0] quo_reg;

    always_comb
    begin
        num_mag  = num[rbi_pkg::NUM_W-1] ? -num : num;
        den_mag  = den[W-1] ? -den : den;
        scaled   = {num_mag[MW-1:0], {F{1'b0}}};
        rem_init = W'(scaled[SW-1:W]);
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem_init;
        bits_reg[0] <= scaled[W-1:0];
        q_reg[0]    <= '0;
        den_reg[0]  <= den_mag;
        neg_reg[0]  <= num[rbi_pkg::NUM_W-1] ^ den[W-1];
        ovf_reg[0]  <= (rem_init >= den_mag);
    end

    for (genvar k = 1; k <= NS; k++) begin : g_step
        logic [W-1:0] trial;
        logic         ge;

        always_comb
        begin
            trial = {rem_reg[k-1][W-2:0], bits_reg[k-1][W-1]};
            ge    = (trial >= den_reg[k-1]);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? (trial - den_reg[k-1]) : trial;
            bits_reg[k] <= {bits_reg[k-1][W-2:0], 1'b0};
            q_reg[k]    <= {q_reg[k-1][W-2:0], ge};
            den_reg[k]  <= den_reg[k-1];
            neg_reg[k]  <= neg_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
        end
    end

    always_comb
    begin
        if (neg_reg[NS]) begin
            if (ovf_reg[NS] || q_reg[NS] > W'(1) << (W - 1))
                quo_next = rbi_pkg::S32_MIN;
            else
                quo_next = -$signed(q_reg[NS]);
        end else begin
            if (ovf_reg[NS] || q_reg[NS][W-1])
                quo_next = rbi_pkg::S32_MAX;
            else
                quo_next = $signed(q_reg[NS]);
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== sv/ray_box_intersect.sv =====
// Ray against box slab test, fully pipelined.
// Stages: input register, 34-stage restoring divider, slab select, multiply, hit point
// and face (done and the result are registered together at the end).
// Throughput: one ray per cycle; busy is always low and results cannot be stalled.
// Reset: clears all valid bits; half extents return to 0.5 (32768).
module ray_box_intersect (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rbi_pkg::ray_t                       ray,
    output logic                                done,
    output rbi_pkg::hit_t                       result,
    input  logic                                cfg_we,
    input  logic [rbi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbi_pkg::HALF_W-1:0]          cfg_data
);

    localparam int W  = rbi_pkg::COORD_W;
    localparam int HW = rbi_pkg::HALF_W;
    localparam int NW = rbi_pkg::NUM_W;
    localparam int F  = rbi_pkg::FRAC_BITS;
    localparam int PW = rbi_pkg::PROD_W;
    localparam int DL = rbi_pkg::DIV_LAT;

    typedef struct packed {
        logic              miss;
        logic [2:0]        bounded;
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
    } side_t;

    logic [HW-1:0] half_reg [0:2];

    logic          in_valid_reg;
    logic [W-1:0]  in_o_reg [0:2];
    logic [W-1:0]  in_d_reg [0:2];
    logic [HW-1:0] in_h_reg [0:2];

    side_t         side_next;
    side_t         side_reg [0:DL-1];
    logic [DL-1:0] side_valid_reg;

    logic signed [NW-1:0] num_lo [0:2];
    logic signed [NW-1:0] num_hi [0:2];
    logic signed [W-1:0]  q_lo   [0:2];
    logic signed [W-1:0]  q_hi   [0:2];

    logic signed [W-1:0] lo_c [0:2];
    logic signed [W-1:0] hi_c [0:2];
    logic signed [W-1:0] tin_c;
    logic signed [W-1:0] tout_c;
    logic                hit_next;
    logic signed [W-1:0] t_next;

    logic                sel_valid_reg;
    logic                sel_hit_reg;
    logic signed [W-1:0] sel_t_reg;
    logic signed [W-1:0] sel_lo_reg [1:2];
    logic signed [W-1:0] sel_hi_reg [1:2];
    logic [2:1]          sel_bnd_reg;
    logic [W-1:0]        sel_o_reg [0:2];
    logic [W-1:0]        sel_d_reg [0:2];

    logic [1:0]           axis_next;
    logic                 mul_valid_reg;
    logic                 mul_hit_reg;
    logic signed [W-1:0]  mul_t_reg;
    logic [1:0]           mul_axis_reg;
    logic signed [PW-1:0] mul_prod_reg [0:2];
    logic [W-1:0]         mul_o_reg [0:2];

    logic signed [W-1:0] pos_c [0:2];
    logic [2:0]          normal_c;
    rbi_pkg::hit_t       result_next;
    rbi_pkg::hit_t       result_reg;
    logic                done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= rbi_pkg::HALF_RESET;
            half_reg[1] <= rbi_pkg::HALF_RESET;
            half_reg[2] <= rbi_pkg::HALF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbi_pkg::CFG_HALF_WIDTH:  half_reg[0] <= cfg_data;
                rbi_pkg::CFG_HALF_HEIGHT: half_reg[1] <= cfg_data;
                rbi_pkg::CFG_HALF_LENGTH: half_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        in_o_reg[0] <= ray.origin_x;
        in_o_reg[1] <= ray.origin_y;
        in_o_reg[2] <= ray.origin_z;
        in_d_reg[0] <= ray.dir_x;
        in_d_reg[1] <= ray.dir_y;
        in_d_reg[2] <= ray.dir_z;
        for (int a = 0; a < 3; a++)
            in_h_reg[a] <= half_reg[a];
    end

    always_comb
    begin
        side_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            num_lo[a] = -$signed(NW'(in_h_reg[a])) - NW'($signed(in_o_reg[a]));
            num_hi[a] = $signed(NW'(in_h_reg[a])) - NW'($signed(in_o_reg[a]));
            side_next.o[a]       = in_o_reg[a];
            side_next.d[a]       = in_d_reg[a];
            side_next.bounded[a] = (in_d_reg[a] != '0);
            if (in_d_reg[a] == '0 && (num_lo[a] > 0 || num_hi[a] < 0))
                side_next.miss = 1'b1;
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        rbi_div u_div_lo (
            .clk (clk),
            .num (num_lo[a]),
            .den (in_d_reg[a]),
            .quo (q_lo[a])
        );
        rbi_div u_div_hi (
            .clk (clk),
            .num (num_hi[a]),
            .den (in_d_reg[a]),
            .quo (q_hi[a])
        );
    end

    // carry the ray alongside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_valid_reg <= '0;
        else
            side_valid_reg <= {side_valid_reg[DL-2:0], in_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < DL; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // slab select
    always_comb
    begin
        tin_c  = rbi_pkg::S32_MIN;
        tout_c = rbi_pkg::S32_MAX;
        for (int a = 0; a < 3; a++)
        begin
            lo_c[a] = (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
            hi_c[a] = (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
        end
        for (int a = 0; a < 3; a++)
        begin
            if (side_reg[DL-1].bounded[a] && lo_c[a] > tin_c)
                tin_c = lo_c[a];
            if (side_reg[DL-1].bounded[a] && hi_c[a] < tout_c)
                tout_c = hi_c[a];
        end
        hit_next = !side_reg[DL-1].miss && (side_reg[DL-1].bounded != '0)
                   && !(tin_c > tout_c) && tout_c > 0 && tin_c != '0;
        t_next   = (tin_c > 0) ? tin_c : tout_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else
            sel_valid_reg <= side_valid_reg[DL-1];
    end

    always_ff @(posedge clk)
    begin
        sel_hit_reg <= hit_next;
        sel_t_reg   <= t_next;
        for (int a = 1; a < 3; a++)
        begin
            sel_lo_reg[a]  <= lo_c[a];
            sel_hi_reg[a]  <= hi_c[a];
            sel_bnd_reg[a] <= side_reg[DL-1].bounded[a];
        end
        for (int a = 0; a < 3; a++)
        begin
            sel_o_reg[a] <= side_reg[DL-1].o[a];
            sel_d_reg[a] <= side_reg[DL-1].d[a];
        end
    end

    // multiply and face axis
    always_comb
    begin
        if (sel_bnd_reg[1] && (sel_t_reg == sel_lo_reg[1] || sel_t_reg == sel_hi_reg[1]))
            axis_next = rbi_pkg::AXIS_Y;
        else if (sel_bnd_reg[2]
                 && (sel_t_reg == sel_lo_reg[2] || sel_t_reg == sel_hi_reg[2]))
            axis_next = rbi_pkg::AXIS_Z;
        else
            axis_next = rbi_pkg::AXIS_X;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else
            mul_valid_reg <= sel_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        mul_hit_reg  <= sel_hit_reg;
        mul_t_reg    <= sel_t_reg;
        mul_axis_reg <= axis_next;
        for (int a = 0; a < 3; a++)
        begin
            mul_prod_reg[a] <= PW'(sel_t_reg) * PW'($signed(sel_d_reg[a]));
            mul_o_reg[a]    <= sel_o_reg[a];
        end
    end

    // hit point, face and output register
    always_comb
    begin
        logic signed [PW-F-1:0] step;
        logic signed [PW:0]     sum;
        for (int a = 0; a < 3; a++)
        begin
            step = (PW-F)'(mul_prod_reg[a] >>> F);
            if (mul_prod_reg[a][PW-1] && mul_prod_reg[a][F-1:0] != '0)
                step = step + (PW-F)'(1);
            sum = (PW+1)'($signed(mul_o_reg[a])) + (PW+1)'(step);
            if (sum > (PW+1)'(rbi_pkg::S32_MAX))
                pos_c[a] = rbi_pkg::S32_MAX;
            else if (sum < (PW+1)'(rbi_pkg::S32_MIN))
                pos_c[a] = rbi_pkg::S32_MIN;
            else
                pos_c[a] = W'(sum);
        end
        case (mul_axis_reg)
            rbi_pkg::AXIS_Y:
                normal_c = (pos_c[1] > 0) ? rbi_pkg::NORMAL_POS_Y : rbi_pkg::NORMAL_NEG_Y;
            rbi_pkg::AXIS_Z:
                normal_c = (pos_c[2] > 0) ? rbi_pkg::NORMAL_POS_Z : rbi_pkg::NORMAL_NEG_Z;
            default:
                normal_c = (pos_c[0] > 0) ? rbi_pkg::NORMAL_POS_X : rbi_pkg::NORMAL_NEG_X;
        endcase
        result_next = '0;
        if (mul_hit_reg)
        begin
            result_next.hit         = 1'b1;
            result_next.t_hit       = mul_t_reg[HW-1:0];
            result_next.pos_x       = pos_c[0];
            result_next.pos_y       = pos_c[1];
            result_next.pos_z       = pos_c[2];
            result_next.normal_code = normal_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mul_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_hit_t_pos: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid_reg && sel_hit_reg |-> sel_t_reg > 0)
        else $error("hit with non-positive distance");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> result.t_hit == '0 && result.normal_code == '0
            && result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0)
        else $error("miss result not cleared");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.normal_code <= rbi_pkg::NORMAL_NEG_Z)
        else $error("normal code out of range");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg |=> done)
        else $error("pipeline dropped a transaction");
`endif

endmodule

// ===== tb/ray_box_checker.sv =====
module ray_box_checker
    import rbi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ray_t              ray,
    input  logic              done,
    input  hit_t              result,
    input  logic              cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending_hits,
    output int                hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    longint half_ext [3];
    hit_t   expected_hits [$];

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint slab_distance(longint num, longint d);
        longint scaled;
        scaled = num * (64'sd1 <<< FRAC_BITS);
        return clamp_s32(scaled / d);
    endfunction

    function automatic hit_t intersect_ray(ray_t r);
        hit_t   res;
        longint o [3];
        longint d [3];
        longint lo [3];
        longint hi [3];
        longint pos [3];
        bit     bounded [3];
        bit     miss;
        bit     have;
        longint tin;
        longint tout;
        longint t;
        longint s;
        int     axis;
        res = '0;
        miss = 0;
        have = 0;
        tin = 0;
        tout = 0;
        o[0] = longint'(r.origin_x);
        o[1] = longint'(r.origin_y);
        o[2] = longint'(r.origin_z);
        d[0] = longint'(r.dir_x);
        d[1] = longint'(r.dir_y);
        d[2] = longint'(r.dir_z);
        for (int a = 0; a < 3; a++)
        begin
            bounded[a] = 0;
            lo[a] = 0;
            hi[a] = 0;
            if (d[a] == 0)
            begin
                if (o[a] < -half_ext[a] || o[a] > half_ext[a])
                    miss = 1;
                continue;
            end
            bounded[a] = 1;
            lo[a] = slab_distance(-half_ext[a] - o[a], d[a]);
            hi[a] = slab_distance(half_ext[a] - o[a], d[a]);
            if (lo[a] > hi[a])
            begin
                s = lo[a];
                lo[a] = hi[a];
                hi[a] = s;
            end
            if (!have)
            begin
                tin = lo[a];
                tout = hi[a];
                have = 1;
            end
            else
            begin
                if (lo[a] > tin)
                    tin = lo[a];
                if (hi[a] < tout)
                    tout = hi[a];
            end
        end
        if (miss || !have || tin > tout)
            return res;
        if (tin > 0 && tout > 0)
            t = tin;
        else if (tin < 0 && tout > 0)
            t = tout;
        else
            return res;
        for (int a = 0; a < 3; a++)
            pos[a] = clamp_s32(o[a] + (t * d[a]) / (64'sd1 <<< FRAC_BITS));
        if (bounded[1] && (t == lo[1] || t == hi[1]))
            axis = 1;
        else if (bounded[2] && (t == lo[2] || t == hi[2]))
            axis = 2;
        else
            axis = 0;
        res.hit = 1'b1;
        res.t_hit = t[HALF_W-1:0];
        res.pos_x = pos[0][31:0];
        res.pos_y = pos[1][31:0];
        res.pos_z = pos[2][31:0];
        res.normal_code = 3'(axis * 2 + (pos[axis] > 0 ? 0 : 1));
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        hit_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
                half_ext[a] = longint'(HALF_RESET);
            expected_hits.delete();
            fail_count <= 0;
            hits_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                hits_seen <= hits_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected transaction: %p", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (result !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_hits.insert(expected_hits.size(), intersect_ray(ray));
            if (cfg_we)
            begin
                if (cfg_index == CFG_HALF_WIDTH)
                    half_ext[0] = longint'(cfg_data);
                else if (cfg_index == CFG_HALF_HEIGHT)
                    half_ext[1] = longint'(cfg_data);
                else if (cfg_index == CFG_HALF_LENGTH)
                    half_ext[2] = longint'(cfg_data);
            end
        end
    end

    assign pending_hits = expected_hits.size();

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import rbi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    ray_t              ray;
    logic              done;
    hit_t              result;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0] cfg_data;
    int                fail_count;
    int                pending_hits;
    int                hits_seen;
    int                rays_sent;
    int                quiet_cycles;
    bit                idle_allowed;

    ray_box_intersect u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .ray(ray),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ray_box_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .ray(ray),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count),
        .pending_hits(pending_hits), .hits_seen(hits_seen)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord(int unsigned half);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'd0;
            4: return half;
            5: return -half;
            default: return $urandom_range(0, 8 * half + 131072) - 4 * half - 65536;
        endcase
    endfunction

    function automatic logic [31:0] pick_dir();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom();
            1: return 32'd0;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'd1;
            5: return 32'hffff_ffff;
            default: return $urandom_range(0, 262144) - 131072;
        endcase
    endfunction

    task automatic write_half(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_ray(ray_t r);
        int gap;
        if (idle_allowed && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        ray <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rays_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (DIV_LAT + 8) @(posedge clk);
    endtask

    task automatic random_phase(int count, int unsigned hw, int unsigned hh,
                                int unsigned hl);
        ray_t r;
        for (int i = 0; i < count; i++)
        begin
            r.origin_x = pick_coord(hw);
            r.origin_y = pick_coord(hh);
            r.origin_z = pick_coord(hl);
            r.dir_x = pick_dir();
            r.dir_y = pick_dir();
            r.dir_z = pick_dir();
            send_ray(r);
        end
    endtask

    initial
    begin
        ray_t r;
        int unsigned hw;
        int unsigned hh;
        int unsigned hl;
        rst_n = 1'b0;
        start = 1'b0;
        ray = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_HALF_WIDTH;
        cfg_data = '0;
        rays_sent = 0;
        idle_allowed = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = '{32'sh0, 32'sh0, -32'sh20000, 32'sh0, 32'sh0, 32'sh10000};
        send_ray(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{32'sh8000, 32'sh0, -32'sh20000, 32'sh0, 32'sh0, 32'sh10000};
        send_ray(r);
        r = '{32'sh8001, 32'sh0, -32'sh20000, 32'sh0, 32'sh0, 32'sh10000};
        send_ray(r);
        r = '{32'sh20000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{-32'sh8000, 32'sh0, 32'sh0, -32'sh10000, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{32'sh0, 32'sh20000, 32'sh0, 32'sh0, -32'sh10000, 32'sh0};
        send_ray(r);
        r = '{32'sh0, -32'sh20000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0};
        send_ray(r);
        r = '{32'sh0, 32'sh0, 32'sh20000, 32'sh0, 32'sh0, -32'sh10000};
        send_ray(r);
        r = '{-32'sh20000, -32'sh20000, -32'sh20000, 32'sh10000, 32'sh10000,
              32'sh10000};
        send_ray(r);
        r = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000};
        send_ray(r);
        r = '{32'sh80000000, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{32'sh7fffffff, 32'sh0, 32'sh0, 32'shffffffff, 32'sh0, 32'sh0};
        send_ray(r);
        r = '{32'shffffffff, 32'shffffffff, 32'shffffffff, 32'sh1, 32'sh1, 32'sh1};
        send_ray(r);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    hw = 32768;
                    hh = 32768;
                    hl = 32768;
                end
                1:
                begin
                    hw = 0;
                    hh = 0;
                    hl = 0;
                end
                2:
                begin
                    hw = 32'h7fff_ffff;
                    hh = 32'h7fff_ffff;
                    hl = 32'h7fff_ffff;
                end
                3:
                begin
                    hw = 65536;
                    hh = 16384;
                    hl = 200000;
                end
                default:
                begin
                    hw = $urandom_range(0, 400000);
                    hh = $urandom();
                    hh = hh & 32'h7fff_ffff;
                    hl = $urandom_range(1, 100000);
                end
            endcase
            write_half(CFG_HALF_WIDTH, HALF_W'(hw));
            write_half(CFG_HALF_HEIGHT, HALF_W'(hh));
            write_half(CFG_HALF_LENGTH, HALF_W'(hl));
            write_half(CFG_SPARE_IDX, HALF_W'($urandom()));
            idle_allowed = (phase < 5);
            random_phase(255, hw, hh, hl);
            drain();
        end

        $display("rays sent: %0d, results checked: %0d, over six box sizes",
                 rays_sent, hits_seen);
        if (fail_count == 0 && pending_hits == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
